### rtl/core/ffea_pkg.sv
// Shared constants, types and codes for the first-fit extent allocator.
package ffea_pkg;

    // Table geometry and field widths.
    localparam int MAX_EXTENTS = 64;
    localparam int OFF_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int SZ_W        = 14;
    localparam int END_W       = 14;
    localparam int SUM_W       = 15;
    localparam int GRANULES    = 512;
    localparam int GRAN_W      = 9;
    localparam int GRAN_SHIFT  = 3;

    // Heap constants.
    localparam logic [SIZE_W-1:0] HEADER_BYTES   = 13'd16;
    localparam logic [SIZE_W-1:0] HEAP_MAX_BYTES = 13'd4096;
    localparam logic [SIZE_W-1:0] HEAP_MIN_BYTES = 13'd32;
    localparam logic [SIZE_W-1:0] SIZE_SAT       = 13'h1FFF;
    localparam logic [SZ_W-1:0]   ALIGN_MASK     = 14'd7;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        RS_DONE       = 2'd0,
        RS_NO_FIT     = 2'd1,
        RS_TABLE_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_FLAG,
        FS_ACT,
        FS_MFLAG,
        FS_MACT,
        FS_RESP
    } t_state;

    // Operation that the sequencer hands to one cell in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_LOAD,
        CELL_TAKE_RIGHT,
        CELL_TAKE_LEFT,
        CELL_SPLIT,
        CELL_MERGE
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] bytes;
    } t_extent;

    // Values broadcast to every cell.
    typedef struct packed {
        logic [SZ_W-1:0]  sz;
        logic [OFF_W-1:0] p;
        t_extent          ins;
    } t_bcast;

    // Local comparison results of one cell.
    typedef struct packed {
        logic hit;
        logic roomy;
        logic lower;
        logic touch;
    } t_flags;

endpackage

### rtl/core/ffea_if.sv
// Channel interfaces for requests, responses and configuration writes.
interface ffea_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ffea_pkg::SIZE_W-1:0] request_bytes;
    logic [ffea_pkg::OFF_W-1:0]  release_offset;
    modport source (output valid, output opcode, output request_bytes,
                    output release_offset, input ready);
    modport sink (input valid, input opcode, input request_bytes,
                  input release_offset, output ready);
endinterface

interface ffea_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ffea_pkg::OFF_W-1:0] payload_offset;
    logic [1:0]                 status;
    modport source (output valid, output payload_offset, output status, input ready);
    modport sink (input valid, input payload_offset, input status, output ready);
endinterface

interface ffea_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ffea_pkg::SIZE_W-1:0] heap_bytes;
    modport source (output valid, output heap_bytes, input ready);
    modport sink (input valid, input heap_bytes, output ready);
endinterface

### rtl/core/ffea_cell.sv
// One cell of the extent table: holds an extent and trades it with its neighbours.
module ffea_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head,
    input  ffea_pkg::t_cell_op i_op,
    input  ffea_pkg::t_bcast   i_bc,
    input  ffea_pkg::t_extent  i_left,
    input  ffea_pkg::t_extent  i_right,
    output ffea_pkg::t_extent  o_ext,
    output ffea_pkg::t_flags   o_flags
);

    ffea_pkg::t_extent r_ext, n_ext;
    logic [ffea_pkg::END_W-1:0] w_end;
    logic [ffea_pkg::SUM_W-1:0] w_sum;
    logic [ffea_pkg::SUM_W-1:0] w_need;

    // End of this extent, merged size with the right neighbour, split threshold.
    assign w_end  = {2'b00, r_ext.start} + ffea_pkg::END_W'(ffea_pkg::HEADER_BYTES)
                  + {1'b0, r_ext.bytes};
    assign w_sum  = {2'b00, r_ext.bytes} + ffea_pkg::SUM_W'(ffea_pkg::HEADER_BYTES)
                  + {2'b00, i_right.bytes};
    assign w_need = {1'b0, i_bc.sz} + ffea_pkg::SUM_W'(ffea_pkg::HEADER_BYTES);

    // Local comparisons for the search, insert and merge steps.
    always_comb begin
        o_flags.hit    = r_ext.valid && ({1'b0, r_ext.bytes} > i_bc.sz);
        o_flags.roomy  = r_ext.valid && ({2'b00, r_ext.bytes} > w_need);
        o_flags.lower  = r_ext.valid && (r_ext.start < i_bc.p);
        o_flags.touch  = r_ext.valid && i_right.valid
                       && (w_end == {2'b00, i_right.start});
    end

    // Next contents of the cell.
    always_comb begin
        n_ext = r_ext;
        case (i_op)
            ffea_pkg::CELL_HOLD:       n_ext = r_ext;
            ffea_pkg::CELL_CLEAR:      n_ext.valid = 1'b0;
            ffea_pkg::CELL_LOAD:       n_ext = i_bc.ins;
            ffea_pkg::CELL_TAKE_RIGHT: n_ext = i_right;
            ffea_pkg::CELL_TAKE_LEFT:  n_ext = i_left;
            ffea_pkg::CELL_SPLIT: begin
                n_ext.start = r_ext.start + ffea_pkg::OFF_W'(ffea_pkg::HEADER_BYTES)
                            + i_bc.sz[ffea_pkg::OFF_W-1:0];
                n_ext.bytes = r_ext.bytes - i_bc.sz[ffea_pkg::SIZE_W-1:0]
                            - ffea_pkg::HEADER_BYTES;
            end
            ffea_pkg::CELL_MERGE: begin
                if (w_sum > ffea_pkg::SUM_W'(ffea_pkg::SIZE_SAT)) begin
                    n_ext.bytes = ffea_pkg::SIZE_SAT;
                end else begin
                    n_ext.bytes = w_sum[ffea_pkg::SIZE_W-1:0];
                end
            end
            default:                   n_ext = r_ext;
        endcase
    end

    // After reset only the head cell holds the whole default heap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext.valid <= i_head;
            r_ext.start <= '0;
            r_ext.bytes <= ffea_pkg::HEAP_MAX_BYTES - ffea_pkg::HEADER_BYTES;
        end else begin
            r_ext <= n_ext;
        end
    end

    assign o_ext = r_ext;

endmodule

### rtl/core/first_fit_extent_allocator_core.sv
// Top level of the first-fit extent allocator: sequencer, cell chain and size memory.
// An allocate steps through the flag, action and response states after acceptance; a free
// that inserts then repeats a merge-flag and merge-action pair, one neighbour merge per pair.
// One transaction is in flight at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) leaves one free extent of 4080 bytes at offset 0.
// A heap size write rebuilds the table, loading the head cell with the clamped heap; the size memory is not cleared.
module first_fit_extent_allocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffea_req_if.sink   i_req,
    ffea_rsp_if.source o_rsp,
    ffea_cfg_if.sink   i_cfg
);

    localparam int N = ffea_pkg::MAX_EXTENTS;

    ffea_pkg::t_state  r_state, n_state;
    ffea_pkg::t_extent w_ext [N];
    ffea_pkg::t_flags  w_flags [N];
    ffea_pkg::t_cell_op w_op [N];
    ffea_pkg::t_bcast  w_bc;
    ffea_pkg::t_extent w_cfg_ext;

    logic                         r_op;
    logic [ffea_pkg::SZ_W-1:0]    r_sz;
    logic [ffea_pkg::OFF_W-1:0]   r_p;
    logic [ffea_pkg::SIZE_W-1:0]  r_rd;
    logic [N-1:0]                 r_vec, r_roomy;
    logic [N-1:0]                 w_valid, w_hit, w_roomy, w_before, w_touch;
    logic [N-1:0]                 w_neg, w_lowest, w_gt;
    logic                         w_found, w_split, w_ins_ok, w_mem_we;
    logic [ffea_pkg::OFF_W-1:0]   w_sel_start, w_pay;
    logic [ffea_pkg::OFF_W-1:0]   r_res_pay, r_out_pay;
    ffea_pkg::t_status            r_res_stat, r_out_stat;
    logic                         r_out_valid;
    logic [ffea_pkg::SIZE_W-1:0]  r_mem [ffea_pkg::GRANULES];
    logic [ffea_pkg::SIZE_W-1:0]  w_heap;
    logic                         w_req_fire, w_cfg_fire, w_load_out;

    assign w_req_fire = i_req.valid && i_req.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_req.ready = (r_state == ffea_pkg::FS_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_load_out  = (r_state == ffea_pkg::FS_RESP) && (!r_out_valid || o_rsp.ready);

    // Cell chain; the ends see an empty neighbour.
    for (genvar k = 0; k < N; k++) begin : g_cell
        ffea_pkg::t_extent w_l, w_r;
        if (k == 0) begin : g_lend
            assign w_l = '0;
        end else begin : g_lmid
            assign w_l = w_ext[k-1];
        end
        if (k == N - 1) begin : g_rend
            assign w_r = '0;
        end else begin : g_rmid
            assign w_r = w_ext[k+1];
        end
        ffea_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_head  (k == 0),
            .i_op    (w_op[k]),
            .i_bc    (w_bc),
            .i_left  (w_l),
            .i_right (w_r),
            .o_ext   (w_ext[k]),
            .o_flags (w_flags[k])
        );
    end

    // Gather per-cell flags into vectors.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_valid[k]  = w_ext[k].valid;
            w_hit[k]    = w_flags[k].hit;
            w_roomy[k]  = w_flags[k].roomy;
            w_before[k] = w_flags[k].lower;
            w_touch[k]  = w_flags[k].touch;
        end
    end

    // Lowest set flag and the cells above it.
    assign w_neg    = ~r_vec + N'(1);
    assign w_lowest = r_vec & w_neg;
    assign w_gt     = (r_vec | w_neg) & ~w_lowest;
    assign w_found  = (r_vec != '0);
    assign w_split  = |(w_lowest & r_roomy);
    assign w_ins_ok = (r_p >= ffea_pkg::OFF_W'(ffea_pkg::HEADER_BYTES)) && !w_valid[N-1];

    // Start of the chosen extent.
    always_comb begin
        w_sel_start = '0;
        for (int k = 0; k < N; k++) begin
            if (w_lowest[k]) begin
                w_sel_start = w_sel_start | w_ext[k].start;
            end
        end
    end
    assign w_pay = w_sel_start + ffea_pkg::OFF_W'(ffea_pkg::HEADER_BYTES);

    // Saturated heap size for a rebuild.
    always_comb begin
        if (i_cfg.heap_bytes < ffea_pkg::HEAP_MIN_BYTES) begin
            w_heap = ffea_pkg::HEAP_MIN_BYTES;
        end else if (i_cfg.heap_bytes > ffea_pkg::HEAP_MAX_BYTES) begin
            w_heap = ffea_pkg::HEAP_MAX_BYTES;
        end else begin
            w_heap = i_cfg.heap_bytes;
        end
        w_cfg_ext.valid = 1'b1;
        w_cfg_ext.start = '0;
        w_cfg_ext.bytes = w_heap - ffea_pkg::HEADER_BYTES;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffea_pkg::FS_IDLE:  if (w_req_fire) n_state = ffea_pkg::FS_FLAG;
            ffea_pkg::FS_FLAG:  n_state = ffea_pkg::FS_ACT;
            ffea_pkg::FS_ACT: begin
                if (r_op == ffea_pkg::OP_FREE && w_ins_ok) begin
                    n_state = ffea_pkg::FS_MFLAG;
                end else begin
                    n_state = ffea_pkg::FS_RESP;
                end
            end
            ffea_pkg::FS_MFLAG: n_state = ffea_pkg::FS_MACT;
            ffea_pkg::FS_MACT: begin
                if (w_found) begin
                    n_state = ffea_pkg::FS_MFLAG;
                end else begin
                    n_state = ffea_pkg::FS_RESP;
                end
            end
            ffea_pkg::FS_RESP:  if (w_load_out) n_state = ffea_pkg::FS_IDLE;
            default:            n_state = ffea_pkg::FS_IDLE;
        endcase
    end

    // Cell operations, broadcast values and memory write.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_op[k] = ffea_pkg::CELL_HOLD;
        end
        w_bc.sz        = r_sz;
        w_bc.p         = r_p;
        w_bc.ins.valid = 1'b1;
        w_bc.ins.start = r_p - ffea_pkg::OFF_W'(ffea_pkg::HEADER_BYTES);
        w_bc.ins.bytes = r_rd;
        w_mem_we       = 1'b0;
        if (w_cfg_fire) begin
            w_bc.ins = w_cfg_ext;
            for (int k = 0; k < N; k++) begin
                w_op[k] = (k == 0) ? ffea_pkg::CELL_LOAD : ffea_pkg::CELL_CLEAR;
            end
        end else begin
            case (r_state)
                ffea_pkg::FS_ACT: begin
                    if (r_op == ffea_pkg::OP_ALLOC && w_found) begin
                        w_mem_we = 1'b1;
                        for (int k = 0; k < N; k++) begin
                            if (w_lowest[k]) begin
                                w_op[k] = w_split ? ffea_pkg::CELL_SPLIT
                                                  : ffea_pkg::CELL_TAKE_RIGHT;
                            end else if (w_gt[k] && !w_split) begin
                                w_op[k] = ffea_pkg::CELL_TAKE_RIGHT;
                            end
                        end
                    end else if (r_op == ffea_pkg::OP_FREE && w_ins_ok) begin
                        for (int k = 0; k < N; k++) begin
                            if (w_lowest[k]) begin
                                w_op[k] = ffea_pkg::CELL_LOAD;
                            end else if (w_gt[k]) begin
                                w_op[k] = ffea_pkg::CELL_TAKE_LEFT;
                            end
                        end
                    end
                end
                ffea_pkg::FS_MACT: begin
                    for (int k = 0; k < N; k++) begin
                        if (w_lowest[k]) begin
                            w_op[k] = ffea_pkg::CELL_MERGE;
                        end else if (w_gt[k]) begin
                            w_op[k] = ffea_pkg::CELL_TAKE_RIGHT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffea_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture, flag registers and result of the action step.
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_op <= i_req.opcode;
            r_sz <= ({1'b0, i_req.request_bytes} + ffea_pkg::ALIGN_MASK)
                  & ~ffea_pkg::ALIGN_MASK;
            r_p  <= i_req.release_offset;
        end
        if (r_state == ffea_pkg::FS_FLAG) begin
            r_vec   <= (r_op == ffea_pkg::OP_ALLOC) ? w_hit : ~w_before;
            r_roomy <= w_roomy;
        end else if (r_state == ffea_pkg::FS_MFLAG) begin
            r_vec <= w_touch;
        end
        if (r_state == ffea_pkg::FS_ACT) begin
            if (r_op == ffea_pkg::OP_ALLOC) begin
                r_res_pay  <= w_found ? w_pay : '0;
                r_res_stat <= w_found ? ffea_pkg::RS_DONE : ffea_pkg::RS_NO_FIT;
            end else begin
                r_res_pay  <= '0;
                if (r_p >= ffea_pkg::OFF_W'(ffea_pkg::HEADER_BYTES) && w_valid[N-1]) begin
                    r_res_stat <= ffea_pkg::RS_TABLE_FULL;
                end else begin
                    r_res_stat <= ffea_pkg::RS_DONE;
                end
            end
        end
    end

    // Granted size per granule; read on acceptance of a transaction.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_pay[ffea_pkg::OFF_W-1:ffea_pkg::GRAN_SHIFT]] <=
                r_sz[ffea_pkg::SIZE_W-1:0];
        end
        if (w_req_fire) begin
            r_rd <= r_mem[i_req.release_offset[ffea_pkg::OFF_W-1:ffea_pkg::GRAN_SHIFT]];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_out_pay  <= r_res_pay;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.payload_offset = r_out_pay;
    assign o_rsp.status         = r_out_stat;

    // The occupied cells always form an unbroken run from the head.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + N'(1))) == '0)
        else $error("extent table has a gap");

    // An insert always finds a position in a table that is not full.
    a_ins_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffea_pkg::FS_ACT && r_op == ffea_pkg::OP_FREE && w_ins_ok)
        |-> w_found)
        else $error("free found no insert position");

    // Each merge step removes exactly one extent.
    a_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffea_pkg::FS_MACT && w_found && !w_cfg_fire)
        |=> ($countones(w_valid) == $countones($past(w_valid)) - 1))
        else $error("merge did not shorten the table");

endmodule

### dv/tb_first_fit_extent_allocator_core.sv
// Self-checking testbench for the first-fit extent allocator core.
`timescale 1ns / 1ps

module tb_first_fit_extent_allocator_core;

    logic i_clk;
    logic i_rst_n;

    ffea_req_if req_ch ();
    ffea_rsp_if rsp_ch ();
    ffea_cfg_if cfg_ch ();

    first_fit_extent_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Directed stimulus row; where known is set the result is typed in.
    typedef struct {
        ffea_pkg::t_opcode           op;
        logic [ffea_pkg::SIZE_W-1:0] rq;
        logic [ffea_pkg::OFF_W-1:0]  rel;
        bit                          known;
        logic [ffea_pkg::OFF_W-1:0]  off;
        ffea_pkg::t_status           st;
    } t_row;

    typedef struct {
        logic [ffea_pkg::OFF_W-1:0] off;
        ffea_pkg::t_status          st;
    } t_result;

    localparam int N_ROWS = 14;
    t_row directed_rows [N_ROWS] = '{
        '{ffea_pkg::OP_ALLOC, 13'd0,    12'd0,  1'b1, 12'd16, ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd1,    12'd0,  1'b1, 12'd32, ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd4096, 12'd0,  1'b1, 12'd0,  ffea_pkg::RS_NO_FIT},
        '{ffea_pkg::OP_ALLOC, 13'd8191, 12'd0,  1'b1, 12'd0,  ffea_pkg::RS_NO_FIT},
        '{ffea_pkg::OP_FREE,  13'd0,    12'd0,  1'b1, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_FREE,  13'd0,    12'd15, 1'b1, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_FREE,  13'd8191, 12'd32, 1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_FREE,  13'd0,    12'd16, 1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd7,    12'd0,  1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd16,   12'd0,  1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_FREE,  13'd0,    12'd35, 1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_FREE,  13'd0,    12'd32, 1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd4030, 12'd0,  1'b0, 12'd0,  ffea_pkg::RS_DONE},
        '{ffea_pkg::OP_ALLOC, 13'd8,    12'd0,  1'b0, 12'd0,  ffea_pkg::RS_DONE}
    };

    // Mirror of the free-extent table and the granule size memory.
    logic [ffea_pkg::OFF_W-1:0]  free_start [ffea_pkg::MAX_EXTENTS];
    logic [ffea_pkg::SIZE_W-1:0] free_bytes [ffea_pkg::MAX_EXTENTS];
    int                          free_count;
    logic [ffea_pkg::SIZE_W-1:0] granule_size [ffea_pkg::GRANULES];
    bit                          granule_written [ffea_pkg::GRANULES];
    int                          written_granules [$];
    logic [ffea_pkg::OFF_W-1:0]  live_blocks [$];

    t_result pending_results [$];
    bit      typed_valid;
    t_result typed_result;
    bit      failed;
    int      tx_idle;
    int      rx_idle;

    function automatic void rebuild_table(input logic [ffea_pkg::SIZE_W-1:0] value);
        int v;
        v = value;
        if (v < 32) v = 32;
        if (v > 4096) v = 4096;
        free_count    = 1;
        free_start[0] = '0;
        free_bytes[0] = ffea_pkg::SIZE_W'(v - 16);
        live_blocks.delete();
    endfunction

    // Merge neighbours whose extents touch exactly.
    function automatic void merge_neighbours();
        int i;
        int stop;
        int sum;
        i = 0;
        while (i + 1 < free_count) begin
            stop = int'(free_start[i]) + 16 + int'(free_bytes[i]);
            if (stop == int'(free_start[i+1])) begin
                sum = int'(free_bytes[i]) + 16 + int'(free_bytes[i+1]);
                if (sum > 8191) sum = 8191;
                free_bytes[i] = ffea_pkg::SIZE_W'(sum);
                for (int k = i + 1; k + 1 < free_count; k++) begin
                    free_start[k] = free_start[k+1];
                    free_bytes[k] = free_bytes[k+1];
                end
                free_count--;
            end else begin
                i++;
            end
        end
    endfunction

    // Work out the result of one request and advance the mirrored state.
    function automatic t_result predict_allocator(input ffea_pkg::t_opcode op,
                                                  input logic [ffea_pkg::SIZE_W-1:0] rq,
                                                  input logic [ffea_pkg::OFF_W-1:0] rel);
        t_result r;
        int sz;
        int idx;
        int st;
        int by;
        int pos;
        int payload;
        r.off = '0;
        r.st  = ffea_pkg::RS_DONE;
        if (op == ffea_pkg::OP_ALLOC) begin
            sz = rq;
            if (sz % 8 != 0) sz = sz - (sz % 8) + 8;
            idx = -1;
            for (int i = 0; i < free_count; i++) begin
                if (idx < 0 && int'(free_bytes[i]) > sz) idx = i;
            end
            if (idx < 0) begin
                r.st = ffea_pkg::RS_NO_FIT;
            end else begin
                st = free_start[idx];
                by = free_bytes[idx];
                if (by > sz + 16) begin
                    free_start[idx] = ffea_pkg::OFF_W'(st + 16 + sz);
                    free_bytes[idx] = ffea_pkg::SIZE_W'(by - sz - 16);
                end else begin
                    for (int k = idx; k + 1 < free_count; k++) begin
                        free_start[k] = free_start[k+1];
                        free_bytes[k] = free_bytes[k+1];
                    end
                    free_count--;
                end
                payload = (st + 16) & 12'hFFF;
                r.off = ffea_pkg::OFF_W'(payload);
                granule_size[payload / 8] = ffea_pkg::SIZE_W'(sz);
                if (!granule_written[payload / 8]) written_granules.push_back(payload / 8);
                granule_written[payload / 8] = 1'b1;
                live_blocks.push_back(ffea_pkg::OFF_W'(payload));
            end
        end else if (rel >= 16) begin
            if (free_count >= ffea_pkg::MAX_EXTENTS) begin
                r.st = ffea_pkg::RS_TABLE_FULL;
            end else begin
                pos = 0;
                while (pos < free_count && free_start[pos] < rel) pos++;
                for (int k = free_count; k > pos; k--) begin
                    free_start[k] = free_start[k-1];
                    free_bytes[k] = free_bytes[k-1];
                end
                free_start[pos] = rel - 12'd16;
                free_bytes[pos] = granule_size[rel / 8];
                free_count++;
                merge_neighbours();
            end
        end
        return r;
    endfunction

    // Sample both channels at the rising edge: predict on acceptance, check on arrival.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) rebuild_table(cfg_ch.heap_bytes);
            if (req_ch.valid && req_ch.ready) begin
                want = predict_allocator(ffea_pkg::t_opcode'(req_ch.opcode),
                                         req_ch.request_bytes, req_ch.release_offset);
                if (typed_valid) want = typed_result;
                pending_results.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.off = rsp_ch.payload_offset;
                got.st  = ffea_pkg::t_status'(rsp_ch.status);
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected response offset %0d status %0d",
                             $time, got.off, got.st);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.off !== want.off) begin
                        $display("%0t: payload_offset expected %0d actual %0d",
                                 $time, want.off, got.off);
                        failed = 1'b1;
                    end
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, got.st);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Response back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send_request(input ffea_pkg::t_opcode op,
                                input logic [ffea_pkg::SIZE_W-1:0] rq,
                                input logic [ffea_pkg::OFF_W-1:0] rel);
        while ($urandom_range(99) < tx_idle) @(negedge i_clk);
        req_ch.valid          = 1'b1;
        req_ch.opcode         = op;
        req_ch.request_bytes  = rq;
        req_ch.release_offset = rel;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        typed_valid  = 1'b0;
    endtask

    // Heap size is only rewritten once every response has come back.
    task automatic write_heap_size(input logic [ffea_pkg::SIZE_W-1:0] value);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.heap_bytes = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One random request, mostly frees of live blocks and modest allocations.
    task automatic random_request(input int heap_limit);
        int pick;
        int idx;
        int g;
        logic [ffea_pkg::OFF_W-1:0] p;
        pick = $urandom_range(99);
        if (pick >= 50 && pick < 88 && live_blocks.size() != 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            p = live_blocks[idx];
            live_blocks.delete(idx);
            send_request(ffea_pkg::OP_FREE, 13'($urandom), p);
        end else if (pick >= 88 && pick < 93) begin
            send_request(ffea_pkg::OP_FREE, 13'($urandom), 12'($urandom_range(15)));
        end else if (pick >= 93 && written_granules.size() != 0) begin
            // Double or misaligned free of a granule that has been written.
            g = written_granules[$urandom_range(written_granules.size() - 1)];
            send_request(ffea_pkg::OP_FREE, 13'($urandom),
                         ffea_pkg::OFF_W'(g * 8 + $urandom_range(7)));
        end else if ($urandom_range(9) == 0) begin
            send_request(ffea_pkg::OP_ALLOC, 13'($urandom), 12'($urandom));
        end else begin
            send_request(ffea_pkg::OP_ALLOC, 13'($urandom_range(heap_limit / 8)),
                         12'($urandom));
        end
    endtask

    initial begin
        logic [ffea_pkg::SIZE_W-1:0] heap_settings [8] = '{13'd5, 13'd8191, 13'd0, 13'd32,
                                                          13'd1000, 13'd200, 13'd4096,
                                                          13'd2500};
        int item_count;
        int heap_now;
        int idx;

        failed         = 1'b0;
        typed_valid    = 1'b0;
        tx_idle        = 25;
        rx_idle        = 52;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = ffea_pkg::OP_ALLOC;
        req_ch.request_bytes  = '0;
        req_ch.release_offset = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.heap_bytes = '0;
        rsp_ch.ready      = 1'b0;
        for (int g = 0; g < ffea_pkg::GRANULES; g++) begin
            granule_size[g]    = '0;
            granule_written[g] = 1'b0;
        end
        rebuild_table(13'd4096);

        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table against the reset heap.
        for (int r = 0; r < N_ROWS; r++) begin
            typed_valid  = directed_rows[r].known;
            typed_result = '{directed_rows[r].off, directed_rows[r].st};
            send_request(directed_rows[r].op, directed_rows[r].rq, directed_rows[r].rel);
        end

        // Fill the heap with tiny blocks, then free every other one so that the table runs full.
        write_heap_size(13'd4096);
        repeat (140) send_request(ffea_pkg::OP_ALLOC, 13'd0, 12'd0);
        for (int k = 0; k < 70; k++) begin
            send_request(ffea_pkg::OP_FREE, 13'd0, live_blocks[2 * k]);
        end
        item_count = N_ROWS + 210;

        // Random phases across the heap settings; the idle rates swap after 600 items and drop to zero after 1150.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 8) begin
                write_heap_size(heap_settings[ph]);
                heap_now = heap_settings[ph];
            end else begin
                heap_now = $urandom_range(4096, 32);
                write_heap_size(ffea_pkg::SIZE_W'(heap_now));
            end
            if (heap_now < 32) heap_now = 32;
            if (heap_now > 4096) heap_now = 4096;
            for (int n = 0; n < 170; n++) begin
                if (item_count > 1150) begin
                    tx_idle = 0;
                    rx_idle = 0;
                end else if (item_count > 600) begin
                    tx_idle = 52;
                    rx_idle = 25;
                end
                random_request(heap_now);
                item_count++;
            end
        end

        // Drain and let the block settle.
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/ffea_pkg.sv
rtl/core/ffea_if.sv
rtl/core/ffea_cell.sv
rtl/core/first_fit_extent_allocator_core.sv
dv/tb_first_fit_extent_allocator_core.sv
